FILE: rtl/core/hjmc_pkg.sv
// Shared types and constants for the hash join match counter.
`default_nettype none

package hjmc_pkg;

    // Field widths fixed by the transaction format
    localparam int KEY_W     = 64;
    localparam int CMD_W     = 2;
    localparam int MATCH_W   = 11;
    localparam int TOTAL_W   = 48;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Command codes; the fourth code is unused and changes nothing
    typedef enum logic [CMD_W-1:0] {
        CMD_BUILD = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Control part of a token that travels down the cell chain
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic full;
    } tok_ctl_t;

endpackage : hjmc_pkg

`default_nettype wire

FILE: rtl/core/hjmc_in_if.sv
// Input channel: command and join key with valid/ready handshake.
`default_nettype none

interface hjmc_in_if;
    logic                          valid;
    logic                          ready;
    logic [hjmc_pkg::CMD_W-1:0]    cmd;
    logic [hjmc_pkg::KEY_W-1:0]    key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface : hjmc_in_if

`default_nettype wire

FILE: rtl/core/hjmc_out_if.sv
// Result channel: match count, running total and table-full flag.
`default_nettype none

interface hjmc_out_if;
    logic                            valid;
    logic                            ready;
    logic [hjmc_pkg::MATCH_W-1:0]    matches_res;
    logic [hjmc_pkg::TOTAL_W-1:0]    total;
    logic                            full_res;

    modport source (output valid, output matches_res, output total, output full_res,
                    input ready);
    modport sink   (input valid, input matches_res, input total, input full_res,
                    output ready);
endinterface : hjmc_out_if

`default_nettype wire

FILE: rtl/core/hjmc_cell.sv
// One table cell: holds one stored key, counts probe hits, passes tokens on.
`default_nettype none

module hjmc_cell #(
    parameter int CAPACITY = 1024,
    parameter int CELL_IDX = 0
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   advance,
    input  hjmc_pkg::tok_ctl_t                    ctl_in,
    input  wire  [hjmc_pkg::KEY_W-1:0]            key_in,
    input  wire  [$clog2(CAPACITY)-1:0]           idx_in,
    input  wire  [$clog2(CAPACITY+1)-1:0]         cnt_in,
    output hjmc_pkg::tok_ctl_t                    ctl_out,
    output logic [hjmc_pkg::KEY_W-1:0]            key_out,
    output logic [$clog2(CAPACITY)-1:0]           idx_out,
    output logic [$clog2(CAPACITY+1)-1:0]         cnt_out
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);

    logic [hjmc_pkg::KEY_W-1:0] key_reg;
    logic                       used_reg;
    logic                       used_next;
    logic                       write_en;
    logic                       hit;
    hjmc_pkg::tok_ctl_t         ctl_reg;
    logic [hjmc_pkg::KEY_W-1:0] tkey_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;

    // Cell update: build token aimed here stores, clear token empties
    always_comb
    begin
        used_next = used_reg;
        write_en  = 1'b0;
        hit       = 1'b0;
        cnt_next  = cnt_in;
        if (ctl_in.valid)
        begin
            case (ctl_in.cmd)
                hjmc_pkg::CMD_BUILD:
                begin
                    if (!ctl_in.full && idx_in == IDX_W'(CELL_IDX))
                    begin
                        write_en  = 1'b1;
                        used_next = 1'b1;
                    end
                end
                hjmc_pkg::CMD_PROBE:
                begin
                    hit = used_reg && (key_reg == key_in);
                end
                hjmc_pkg::CMD_CLEAR:
                begin
                    used_next = 1'b0;
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
        if (hit)
        begin
            cnt_next = cnt_in + CNT_W'(1);
        end
    end

    // Occupancy and token control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            ctl_reg  <= '0;
        end
        else if (advance)
        begin
            used_reg <= used_next;
            ctl_reg  <= ctl_in;
        end
    end

    // Stored key and token payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (write_en)
            begin
                key_reg <= key_in;
            end
            tkey_reg <= key_in;
            idx_reg  <= idx_in;
            cnt_reg  <= cnt_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign key_out = tkey_reg;
    assign idx_out = idx_reg;
    assign cnt_out = cnt_reg;

endmodule : hjmc_cell

`default_nettype wire

FILE: rtl/core/hash_join_match_counter_unit.sv
// Hash join match counter: a chain of key cells with entry and result stages.
//
// Channels: "item" takes a command (build insert, probe, clear) and a 64-bit
// key; "result" returns one transaction per item: the probe match count, the
// running saturating total and a flag for a build rejected on a full table.
// Every item, whatever its command, travels down a chain of CAPACITY cells,
// one cell per cycle while the chain advances; each cell holds one stored key. A build writes the cell
// picked by the entry count when it passes it, a probe counts equal keys on
// its way, a clear empties each cell as it passes. Tokens never overtake, so
// each item sees exactly the table left by the items before it.
// Throughput: one item per cycle while results are taken; the chain is a
// pipeline, so the per-item figure is set only by the result register draining.
// A stalled receiver freezes the whole chain and deasserts item.ready until
// the held result is taken. Reset empties all cells, zeroes the entry count
// and the total and drops any transaction in flight; the block takes items
// in the first cycle after reset.
`default_nettype none

module hash_join_match_counter_unit #(
    parameter int CAPACITY = 1024
) (
    input  wire           clk,
    input  wire           rst_n,
    hjmc_in_if.sink       item,
    hjmc_out_if.source    result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);

    hjmc_pkg::tok_ctl_t          ctl_w [CAPACITY+1];
    logic [hjmc_pkg::KEY_W-1:0]  key_w [CAPACITY+1];
    logic [IDX_W-1:0]            idx_w [CAPACITY+1];
    logic [CNT_W-1:0]            cnt_w [CAPACITY+1];

    logic                        advance;
    logic                        table_full;
    hjmc_pkg::cmd_t              item_cmd;
    logic [CNT_W-1:0]            entry_count_reg;
    logic [CNT_W-1:0]            entry_count_next;

    logic                        result_valid_reg;
    logic [hjmc_pkg::TOTAL_W-1:0] total_reg;
    logic [hjmc_pkg::TOTAL_W-1:0] total_next;
    logic [hjmc_pkg::TOTAL_W:0]  total_sum;
    logic [hjmc_pkg::MATCH_W-1:0] matches_reg;
    logic                        full_reg;
    logic [CNT_W+hjmc_pkg::MATCH_W-1:0] cnt_ext;

    // Whole chain moves when the result register is free or being drained
    assign advance    = !result_valid_reg || result.ready;
    assign item.ready = advance;

    // Entry stage: assign a table slot to builds, detect a full table
    assign item_cmd   = hjmc_pkg::cmd_t'(item.cmd);
    assign table_full = (entry_count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        entry_count_next = entry_count_reg;
        case (item_cmd)
            hjmc_pkg::CMD_BUILD:
            begin
                if (!table_full)
                begin
                    entry_count_next = entry_count_reg + CNT_W'(1);
                end
            end
            hjmc_pkg::CMD_CLEAR:
            begin
                entry_count_next = '0;
            end
            default:
            begin
                entry_count_next = entry_count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (item.valid && advance)
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    assign ctl_w[0].valid = item.valid;
    assign ctl_w[0].cmd   = item_cmd;
    assign ctl_w[0].full  = (item_cmd == hjmc_pkg::CMD_BUILD) && table_full;
    assign key_w[0]       = item.key;
    assign idx_w[0]       = entry_count_reg[IDX_W-1:0];
    assign cnt_w[0]       = '0;

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        hjmc_cell #(
            .CAPACITY (CAPACITY),
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctl_in  (ctl_w[i]),
            .key_in  (key_w[i]),
            .idx_in  (idx_w[i]),
            .cnt_in  (cnt_w[i]),
            .ctl_out (ctl_w[i+1]),
            .key_out (key_w[i+1]),
            .idx_out (idx_w[i+1]),
            .cnt_out (cnt_w[i+1])
        );
    end

    // Result stage: saturating running total, clear zeroes it
    assign total_sum = {1'b0, total_reg}
                     + (hjmc_pkg::TOTAL_W+1)'(cnt_w[CAPACITY]);
    assign cnt_ext   = {{hjmc_pkg::MATCH_W{1'b0}}, cnt_w[CAPACITY]};

    always_comb
    begin
        total_next = total_reg;
        case (ctl_w[CAPACITY].cmd)
            hjmc_pkg::CMD_PROBE:
            begin
                if (total_sum[hjmc_pkg::TOTAL_W])
                begin
                    total_next = hjmc_pkg::TOTAL_MAX;
                end
                else
                begin
                    total_next = total_sum[hjmc_pkg::TOTAL_W-1:0];
                end
            end
            hjmc_pkg::CMD_CLEAR:
            begin
                total_next = '0;
            end
            default:
            begin
                total_next = total_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            total_reg        <= '0;
        end
        else if (advance)
        begin
            result_valid_reg <= ctl_w[CAPACITY].valid;
            if (ctl_w[CAPACITY].valid)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctl_w[CAPACITY].valid)
        begin
            matches_reg <= cnt_ext[hjmc_pkg::MATCH_W-1:0];
            full_reg    <= ctl_w[CAPACITY].full;
        end
    end

    assign result.valid       = result_valid_reg;
    assign result.matches_res = matches_reg;
    assign result.total       = total_reg;
    assign result.full_res    = full_reg;

endmodule : hash_join_match_counter_unit

`default_nettype wire
